// ===== design/fftag_pkg.sv =====
// ----------------------------------------------------------------------------
// fftag_pkg: shared types and constants of the first-fit tag allocator
// Transaction payloads, command codes and boundary-tag field widths.
// ----------------------------------------------------------------------------
package fftag_pkg;

	// Default heap size in bytes
	localparam int HEAP_BYTES_DEF = 1024;

	// Boundary tag layout: bit 15 in use, bits 14:0 length in bytes
	localparam int TAG_W        = 16;
	localparam int TAG_LEN_W    = 15;
	localparam int TAG_USED_BIT = 15;
	localparam int TAG_LEN_MASK = 32'h7FFF;
	localparam int TAG_BYTES    = 2;

	// Padding added before rounding a request up to even: two tags plus one
	localparam int NEED_PAD = 2 * TAG_BYTES + 1;

	// Width of the shared adder: wide enough for an unwrapped padded request
	localparam int ADD_W = 17;

	// Port field widths
	localparam int REQ_W        = 16;
	localparam int ADDR_W       = 10;
	localparam int FREE_BYTES_W = 11;

	// Command codes
	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [REQ_W-1:0]  request_size;
		logic [ADDR_W-1:0] block_address;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]       result_address;
		logic                    ok;
		logic [FREE_BYTES_W-1:0] free_bytes;
	} result_t;

	// Completion and free-counter events from the engine
	typedef struct packed {
		logic                 done;
		logic                 ok;
		logic [ADDR_W-1:0]    addr;
		logic                 free_add;
		logic                 free_sub;
		logic [TAG_LEN_W-1:0] amt;
	} evt_t;

endpackage

// ===== design/first_fit_tag_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_tag_allocator_core: first-fit boundary-tag heap allocator
// A command is taken when start is high and busy is low. Exactly one result
// transaction follows, shown for one cycle with done high; the receiver cannot
// stall it and must take it in that cycle. An allocate walks the tags from
// offset 0 up to the first fitting free block, then marks it in use and
// writes the remainder tag; it fails when no block fits, and at once when
// the request is oversize. A release walks the tags up to the block being
// released, always reads the tag of a block that follows it to decide the
// forward merge, and merges into a free preceding block. A release of an
// unknown address fails when the walk gives up. The walk is bounded by the
// tag memory, one registered read per cycle, so the rate follows heap
// fragmentation. busy drops in the done cycle, so the next command can be
// taken while the result is on the ports. After reset the block is ready
// at once: tag word 0 reads as the whole heap until first written, and no
// other word is ever read before it has been written.
// ----------------------------------------------------------------------------
module first_fit_tag_allocator_core #(
	parameter int HEAP_BYTES = fftag_pkg::HEAP_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  fftag_pkg::item_t    item,
	output logic                done,
	output fftag_pkg::result_t  result
);

	localparam int IDX_W  = $clog2(HEAP_BYTES) - 1;
	localparam int FREE_W = $clog2(HEAP_BYTES + 1);
	localparam int ADD_W  = fftag_pkg::ADD_W;
	// free-byte counter starts at the heap size, cut to the tag length field
	localparam logic [FREE_W-1:0] FREE_RST =
		FREE_W'(HEAP_BYTES & fftag_pkg::TAG_LEN_MASK);

	logic                        start_acc;
	logic                        eng_busy;
	fftag_pkg::evt_t             evt;
	logic                        rd_en;
	logic [IDX_W-1:0]            rd_idx;
	logic [fftag_pkg::TAG_W-1:0] rd_data;
	logic                        wr_en;
	logic [IDX_W-1:0]            wr_idx;
	logic [fftag_pkg::TAG_W-1:0] wr_data;

	logic [FREE_W-1:0]   free_q;
	logic [FREE_W-1:0]   free_d;
	logic [ADD_W-1:0]    free_ext;
	logic [ADD_W-1:0]    amt_ext;
	logic                done_q;
	fftag_pkg::result_t  result_q;

	// Accept a command transaction only while the walk engine is idle
	assign start_acc = start && !eng_busy;
	assign busy      = eng_busy;

	fftag_engine #(
		.HEAP_BYTES (HEAP_BYTES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start_acc (start_acc),
		.item      (item),
		.busy      (eng_busy),
		.evt       (evt),
		.rd_en     (rd_en),
		.rd_idx    (rd_idx),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_idx    (wr_idx),
		.wr_data   (wr_data)
	);

	fftag_store #(
		.HEAP_BYTES (HEAP_BYTES)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_idx  (rd_idx),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);

	// Free-byte counter: add the length of a block that leaves use, take away
	// the body of a new allocation, and floor at zero
	assign free_ext = ADD_W'(free_q);
	assign amt_ext  = ADD_W'(evt.amt);

	always_comb begin
		free_d = free_q;
		if (evt.free_add) begin
			free_d = FREE_W'(free_ext + amt_ext);
		end else if (evt.free_sub) begin
			free_d = (free_ext >= amt_ext) ? FREE_W'(free_ext - amt_ext) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= FREE_RST;
			done_q <= 1'b0;
		end else begin
			free_q <= free_d;
			done_q <= evt.done;
		end
	end

	// Hold the result transaction for its single cycle on the ports; the
	// counter value is the one after this command
	always_ff @(posedge clk) begin
		if (evt.done) begin
			result_q.result_address <= evt.addr;
			result_q.ok             <= evt.ok;
			result_q.free_bytes     <= fftag_pkg::FREE_BYTES_W'(free_d);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== design/fftag_store.sv =====
// ----------------------------------------------------------------------------
// fftag_store: boundary tag memory
// One word per even byte offset, one write and one registered read port.
// Word 0 reads as the heap size until it is first written.
// ----------------------------------------------------------------------------
module fftag_store #(
	parameter int HEAP_BYTES = fftag_pkg::HEAP_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(HEAP_BYTES)-2:0] rd_idx,
	output logic [fftag_pkg::TAG_W-1:0]  rd_data,
	input  logic                         wr_en,
	input  logic [$clog2(HEAP_BYTES)-2:0] wr_idx,
	input  logic [fftag_pkg::TAG_W-1:0]  wr_data
);

	localparam int WORDS = (HEAP_BYTES + 1) / 2;
	localparam int IDX_W = $clog2(HEAP_BYTES) - 1;
	localparam logic [fftag_pkg::TAG_W-1:0] RESET_TAG =
		fftag_pkg::TAG_W'(HEAP_BYTES & fftag_pkg::TAG_LEN_MASK);

	logic [fftag_pkg::TAG_W-1:0] mem_q [WORDS];
	logic [fftag_pkg::TAG_W-1:0] rd_q;
	logic                        w0_fresh_q;
	logic                        use_rst_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_idx];
		end
	end

	// Track word 0 until its first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_fresh_q <= 1'b1;
			use_rst_q  <= 1'b0;
		end else begin
			if (wr_en && wr_idx == IDX_W'(0)) begin
				w0_fresh_q <= 1'b0;
			end
			if (rd_en) begin
				use_rst_q <= w0_fresh_q && rd_idx == IDX_W'(0);
			end
		end
	end

	assign rd_data = use_rst_q ? RESET_TAG : rd_q;

endmodule

// ===== design/fftag_engine.sv =====
// ----------------------------------------------------------------------------
// fftag_engine: tag walk sequencer
// Small sequencer around one shared add/subtract unit; walks, splits and
// merges boundary tags one memory access per cycle.
// ----------------------------------------------------------------------------
module fftag_engine #(
	parameter int HEAP_BYTES = fftag_pkg::HEAP_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start_acc,
	input  fftag_pkg::item_t              item,
	output logic                          busy,
	output fftag_pkg::evt_t               evt,
	output logic                          rd_en,
	output logic [$clog2(HEAP_BYTES)-2:0] rd_idx,
	input  logic [fftag_pkg::TAG_W-1:0]   rd_data,
	output logic                          wr_en,
	output logic [$clog2(HEAP_BYTES)-2:0] wr_idx,
	output logic [fftag_pkg::TAG_W-1:0]   wr_data
);

	localparam int OFF_W = $clog2(HEAP_BYTES);
	localparam int WORDS = (HEAP_BYTES + 1) / 2;
	localparam int ADD_W = fftag_pkg::ADD_W;
	localparam int LEN_W = fftag_pkg::TAG_LEN_W;
	localparam logic [ADD_W-1:0] HEAP_LIM  = ADD_W'(HEAP_BYTES);
	localparam logic [ADD_W-1:0] STORE_LIM = ADD_W'(2 * WORDS);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_APREP  = 10'b00_0000_0010,
		S_ABODY  = 10'b00_0000_0100,
		S_ACHK   = 10'b00_0000_1000,
		S_ASPLIT = 10'b00_0001_0000,
		S_ADONE  = 10'b00_0010_0000,
		S_RPREP  = 10'b00_0100_0000,
		S_RCHK   = 10'b00_1000_0000,
		S_RNXT   = 10'b01_0000_0000,
		S_RPREV  = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	logic [fftag_pkg::REQ_W-1:0]  req_q;
	logic [fftag_pkg::ADDR_W-1:0] baddr_q;
	logic [ADD_W-1:0]             need_q, need_d;
	logic [LEN_W-1:0]             body_q, body_d;
	logic [LEN_W-1:0]             rem_q, rem_d;
	logic [LEN_W-1:0]             len_q, len_d;
	logic [LEN_W-1:0]             merged_q, merged_d;
	logic [OFF_W-1:0]             off_q, off_d;
	logic [OFF_W-1:0]             prev_q, prev_d;
	logic [fftag_pkg::TAG_W-1:0]  prev_tag_q, prev_tag_d;
	logic                         have_prev_q, have_prev_d;
	logic [fftag_pkg::ADDR_W-1:0] tgt_q, tgt_d;
	logic                         tgt_vld_q, tgt_vld_d;

	// Shared add/subtract unit
	logic [ADD_W-1:0] op_a, op_b, sum;
	logic             op_sub;

	logic [LEN_W-1:0] cur_len;
	logic             cur_used;
	logic             fit;
	logic             hit;
	logic             prev_free;
	logic [LEN_W-1:0] nxt_merged;

	assign cur_len   = rd_data[LEN_W-1:0];
	assign cur_used  = rd_data[fftag_pkg::TAG_USED_BIT];
	assign fit       = !cur_used && ADD_W'(cur_len) >= need_q;
	assign hit       = tgt_vld_q && ADD_W'(off_q) == ADD_W'(tgt_q);
	assign prev_free = have_prev_q && !prev_tag_q[fftag_pkg::TAG_USED_BIT];
	assign nxt_merged = cur_used ? len_q : sum[LEN_W-1:0];
	assign busy      = state_q != S_IDLE;

	// Operand selection
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		case (state_q)
			S_APREP: begin
				op_a = ADD_W'(req_q);
				op_b = ADD_W'(fftag_pkg::NEED_PAD);
			end
			S_ABODY: begin
				op_a   = need_q;
				op_b   = ADD_W'(fftag_pkg::TAG_BYTES);
				op_sub = 1'b1;
			end
			S_ACHK: begin
				if (fit) begin
					op_a   = ADD_W'(cur_len);
					op_b   = ADD_W'(body_q);
					op_sub = 1'b1;
				end else begin
					op_a = ADD_W'(off_q);
					op_b = ADD_W'(cur_len);
				end
			end
			S_ASPLIT: begin
				op_a = ADD_W'(off_q);
				op_b = ADD_W'(body_q);
			end
			S_ADONE: begin
				op_a = ADD_W'(off_q);
				op_b = ADD_W'(fftag_pkg::TAG_BYTES);
			end
			S_RPREP: begin
				op_a   = ADD_W'(baddr_q);
				op_b   = ADD_W'(fftag_pkg::TAG_BYTES);
				op_sub = 1'b1;
			end
			S_RCHK: begin
				op_a = ADD_W'(off_q);
				op_b = ADD_W'(cur_len);
			end
			S_RNXT: begin
				op_a = ADD_W'(len_q);
				op_b = ADD_W'(cur_len);
			end
			S_RPREV: begin
				op_a = ADD_W'(prev_tag_q[LEN_W-1:0]);
				op_b = ADD_W'(merged_q);
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	assign sum = op_a + (op_sub ? ~op_b : op_b) + ADD_W'(op_sub);

	// Sequencer
	always_comb begin
		state_d     = state_q;
		need_d      = need_q;
		body_d      = body_q;
		rem_d       = rem_q;
		len_d       = len_q;
		merged_d    = merged_q;
		off_d       = off_q;
		prev_d      = prev_q;
		prev_tag_d  = prev_tag_q;
		have_prev_d = have_prev_q;
		tgt_d       = tgt_q;
		tgt_vld_d   = tgt_vld_q;
		evt         = '0;
		rd_en       = 1'b0;
		rd_idx      = sum[OFF_W-1:1];
		wr_en       = 1'b0;
		wr_idx      = off_q[OFF_W-1:1];
		wr_data     = '0;
		case (state_q)
			S_IDLE: begin
				if (start_acc) begin
					state_d = (item.cmd == fftag_pkg::CMD_RELEASE) ? S_RPREP : S_APREP;
				end
			end
			S_APREP: begin
				// round the padded request up to even
				need_d  = {sum[ADD_W-1:1], 1'b0};
				state_d = S_ABODY;
			end
			S_ABODY: begin
				body_d = sum[LEN_W-1:0];
				if (need_q > HEAP_LIM) begin
					evt.done = 1'b1;
					state_d  = S_IDLE;
				end else begin
					off_d   = '0;
					rd_en   = 1'b1;
					rd_idx  = '0;
					state_d = S_ACHK;
				end
			end
			S_ACHK: begin
				if (cur_len == '0) begin
					evt.done = 1'b1;
					state_d  = S_IDLE;
				end else if (fit) begin
					// mark the head in use, remainder goes in the next step
					rem_d   = sum[LEN_W-1:0];
					wr_en   = 1'b1;
					wr_data = {1'b1, body_q};
					state_d = S_ASPLIT;
				end else if (sum >= HEAP_LIM) begin
					evt.done = 1'b1;
					state_d  = S_IDLE;
				end else begin
					off_d = sum[OFF_W-1:0];
					rd_en = 1'b1;
				end
			end
			S_ASPLIT: begin
				wr_en   = sum < STORE_LIM;
				wr_idx  = sum[OFF_W-1:1];
				wr_data = {1'b0, rem_q};
				state_d = S_ADONE;
			end
			S_ADONE: begin
				evt.done     = 1'b1;
				evt.ok       = 1'b1;
				evt.addr     = sum[fftag_pkg::ADDR_W-1:0];
				evt.free_sub = 1'b1;
				evt.amt      = body_q;
				state_d      = S_IDLE;
			end
			S_RPREP: begin
				tgt_d       = sum[fftag_pkg::ADDR_W-1:0];
				tgt_vld_d   = |baddr_q[fftag_pkg::ADDR_W-1:1];
				off_d       = '0;
				have_prev_d = 1'b0;
				rd_en       = 1'b1;
				rd_idx      = '0;
				state_d     = S_RCHK;
			end
			S_RCHK: begin
				if (hit) begin
					len_d        = cur_len;
					evt.free_add = cur_used;
					evt.amt      = cur_len;
					if (sum < HEAP_LIM) begin
						rd_en   = 1'b1;
						state_d = S_RNXT;
					end else begin
						wr_en    = 1'b1;
						wr_data  = {1'b0, cur_len};
						merged_d = cur_len;
						if (prev_free) begin
							state_d = S_RPREV;
						end else begin
							evt.done = 1'b1;
							evt.ok   = 1'b1;
							state_d  = S_IDLE;
						end
					end
				end else if (cur_len == '0 || sum >= HEAP_LIM) begin
					evt.done = 1'b1;
					state_d  = S_IDLE;
				end else begin
					prev_d      = off_q;
					prev_tag_d  = rd_data;
					have_prev_d = 1'b1;
					off_d       = sum[OFF_W-1:0];
					rd_en       = 1'b1;
				end
			end
			S_RNXT: begin
				wr_en    = 1'b1;
				wr_data  = {1'b0, nxt_merged};
				merged_d = nxt_merged;
				if (prev_free) begin
					state_d = S_RPREV;
				end else begin
					evt.done = 1'b1;
					evt.ok   = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_RPREV: begin
				wr_en    = 1'b1;
				wr_idx   = prev_q[OFF_W-1:1];
				wr_data  = {1'b0, sum[LEN_W-1:0]};
				evt.done = 1'b1;
				evt.ok   = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start_acc) begin
			req_q   <= item.request_size;
			baddr_q <= item.block_address;
		end
		need_q      <= need_d;
		body_q      <= body_d;
		rem_q       <= rem_d;
		len_q       <= len_d;
		merged_q    <= merged_d;
		off_q       <= off_d;
		prev_q      <= prev_d;
		prev_tag_q  <= prev_tag_d;
		have_prev_q <= have_prev_d;
		tgt_q       <= tgt_d;
		tgt_vld_q   <= tgt_vld_d;
	end

endmodule
